@@ src/pfe_pkg.sv @@
// ----------------------------------------------------------------------------
// pfe_pkg: shared types, constants and grid helpers
// Letter codes, register indexes, the queue entry type and the grid lookup
// functions used by the front and back of the digraph encryptor.
// ----------------------------------------------------------------------------
package pfe_pkg;

   localparam int LETTER_W       = 5;
   localparam int GRID_SIZE      = 5;
   localparam int ROW_W          = LETTER_W * GRID_SIZE;
   localparam int POS_W          = $clog2(GRID_SIZE);
   localparam int CSR_ADDR_W     = 5;
   localparam int CSR_DATA_W     = 32;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
   localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
   localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;
   localparam logic [LETTER_W-1:0] LETTER_Y = 5'd24;

   localparam logic [2:0] REG_GRID_ROW0 = 3'd0;
   localparam logic [2:0] REG_GRID_ROW1 = 3'd1;
   localparam logic [2:0] REG_GRID_ROW2 = 3'd2;
   localparam logic [2:0] REG_GRID_ROW3 = 3'd3;
   localparam logic [2:0] REG_GRID_ROW4 = 3'd4;

   typedef logic [GRID_SIZE-1:0][ROW_W-1:0] grid_type;

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } pos_type;

   // One digraph job; dup marks a repeated letter at line end, sent twice.
   typedef struct packed {
      logic [LETTER_W-1:0] first;
      logic [LETTER_W-1:0] second;
      logic                done;
      logic                dup;
   } pair_type;

   function automatic logic [LETTER_W-1:0] cell_at(input grid_type grid,
                                                   input pos_type pos);
      return grid[pos.row][LETTER_W*pos.col +: LETTER_W];
   endfunction

   // First match in row-major order; a missing letter sits at row 0, col 0.
   function automatic pos_type locate(input grid_type grid,
                                      input logic [LETTER_W-1:0] letter);
      pos_type pos;
      pos_type probe;
      logic    found;
      pos   = '0;
      found = 1'b0;
      for (int r = 0; r < GRID_SIZE; r++) begin
         for (int c = 0; c < GRID_SIZE; c++) begin
            probe.row = POS_W'(r);
            probe.col = POS_W'(c);
            if (!found && cell_at(grid, probe) == letter) begin
               pos   = probe;
               found = 1'b1;
            end
         end
      end
      return pos;
   endfunction

   function automatic logic [POS_W-1:0] wrap_inc(input logic [POS_W-1:0] p);
      return (p == POS_W'(GRID_SIZE - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage

@@ src/pfe_if.sv @@
// ----------------------------------------------------------------------------
// pfe_req_if / pfe_rsp_if: letter and digraph channels
// Valid/ready channels carrying plaintext letters in and cipher pairs out.
// ----------------------------------------------------------------------------
interface pfe_req_if;
   logic       valid;
   logic       ready;
   logic [4:0] plain_letter;
   logic       line_end;

   modport source (output valid, output plain_letter, output line_end, input ready);
   modport sink   (input valid, input plain_letter, input line_end, output ready);
endinterface

interface pfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] cipher_first;
   logic [4:0] cipher_second;
   logic       run_last;
   logic       line_done;

   modport source (output valid, output cipher_first, output cipher_second,
                   output run_last, output line_done, input ready);
   modport sink   (input valid, input cipher_first, input cipher_second,
                   input run_last, input line_done, output ready);
endinterface

@@ src/playfair_digraph_encrypt.sv @@
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt: 5x5 key grid digraph encryptor
// Pairs a stream of plaintext letters and enciphers each pair with the grid.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one plaintext letter (A=0..Z=25) per transfer with a
//   line_end mark on the last letter of a line. J is folded to I.
//   rsp_bus carries enciphered digraphs. A transfer that completes a pair
//   gives one digraph; a repeated letter at line end gives two, the second
//   flagged run_last and line_done. A first letter mid-line gives none.
//   Program the grid rows at byte addresses 0, 4, 8, 12, 16 over APB while
//   the block is idle; column 0 sits in bits 4..0 of each row.
// Timing:
//   One letter per cycle sustained while the queue has room. A digraph
//   passes through the job queue and then through the grid lookup into
//   the result register before it appears on rsp_bus. A repeated pair
//   at line end holds its job in the back until its second send.
// Reset clears the pending letter, empties the queue, drops any result and
//   zeroes the grid. When rsp_bus stalls, the result register holds, the
//   queue fills, and req_bus.ready falls once the queue is full.
// ----------------------------------------------------------------------------
module playfair_digraph_encrypt #(
   parameter int QUEUE_DEPTH = pfe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   pfe_req_if.sink                          req_bus,
   pfe_rsp_if.source                        rsp_bus,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [pfe_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [pfe_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [pfe_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import pfe_pkg::*;

   grid_type         grid_ff;
   logic             csr_write;
   logic [2:0]       csr_index;
   logic             push_valid, push_ready;
   pair_type         push_pair;
   logic             pop_valid, pop_ready;
   pair_type         pop_pair;

   // Register file: write at the access phase, read back the row.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_GRID_ROW0: grid_ff[0] <= pwdata[ROW_W-1:0];
            REG_GRID_ROW1: grid_ff[1] <= pwdata[ROW_W-1:0];
            REG_GRID_ROW2: grid_ff[2] <= pwdata[ROW_W-1:0];
            REG_GRID_ROW3: grid_ff[3] <= pwdata[ROW_W-1:0];
            REG_GRID_ROW4: grid_ff[4] <= pwdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_GRID_ROW0: prdata = CSR_DATA_W'(grid_ff[0]);
         REG_GRID_ROW1: prdata = CSR_DATA_W'(grid_ff[1]);
         REG_GRID_ROW2: prdata = CSR_DATA_W'(grid_ff[2]);
         REG_GRID_ROW3: prdata = CSR_DATA_W'(grid_ff[3]);
         REG_GRID_ROW4: prdata = CSR_DATA_W'(grid_ff[4]);
         default:       prdata = '0;
      endcase
   end

   // Front: pair letters into jobs.
   pfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .push_valid (push_valid),
      .push_pair  (push_pair),
      .push_ready (push_ready)
   );

   // Queue: decouple pairing from the cipher so each side stalls alone.
   pfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_pair  (push_pair),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_pair   (pop_pair),
      .pop_ready  (pop_ready)
   );

   // Back: encipher and hold the result.
   pfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .grid      (grid_ff),
      .pop_valid (pop_valid),
      .pop_pair  (pop_pair),
      .pop_ready (pop_ready),
      .rsp       (rsp_bus)
   );

endmodule

@@ src/pfe_front.sv @@
// ----------------------------------------------------------------------------
// pfe_front: letter intake and pairing
// Folds J to I, holds a pending first letter and emits one digraph job per
// transfer that completes a pair or ends a line.
// ----------------------------------------------------------------------------
module pfe_front (
   input  logic              clock,
   input  logic              reset,
   pfe_req_if.sink           req,
   output logic              push_valid,
   output pfe_pkg::pair_type push_pair,
   input  logic              push_ready
);
   import pfe_pkg::*;

   logic                pend_valid_ff, pend_valid_in;
   logic [LETTER_W-1:0] pend_letter_ff, pend_letter_in;
   logic [LETTER_W-1:0] letter;
   logic                accept;
   logic                repeat_hit;

   assign req.ready  = push_ready;
   assign accept     = req.valid && push_ready;
   assign letter     = (req.plain_letter == LETTER_J) ? LETTER_I : req.plain_letter;
   assign repeat_hit = pend_valid_ff && (letter == pend_letter_ff);
   assign push_valid = accept && (req.line_end || pend_valid_ff);

   always_comb begin
      if (!pend_valid_ff) begin
         push_pair = '{first: letter, second: LETTER_X, done: 1'b1, dup: 1'b0};
      end else if (repeat_hit) begin
         push_pair = '{first: pend_letter_ff, second: LETTER_X,
                       done: req.line_end, dup: req.line_end};
      end else begin
         push_pair = '{first: pend_letter_ff, second: letter,
                       done: req.line_end, dup: 1'b0};
      end
   end

   // Keep pending on a fresh first letter or a repeat inside a line.
   assign pend_valid_in  = accept ? (!req.line_end && (!pend_valid_ff || repeat_hit))
                                  : pend_valid_ff;
   assign pend_letter_in = accept ? letter : pend_letter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff  <= 1'b0;
         pend_letter_ff <= '0;
      end else begin
         pend_valid_ff  <= pend_valid_in;
         pend_letter_ff <= pend_letter_in;
      end
   end

   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req.line_end |=> !pend_valid_ff)
      else $error("pending letter survived a line end");

   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> req.valid && push_ready)
      else $error("job pushed without an input transfer");

endmodule

@@ src/pfe_queue.sv @@
// ----------------------------------------------------------------------------
// pfe_queue: digraph job queue
// Small register FIFO between the pairing front and the cipher back.
// ----------------------------------------------------------------------------
module pfe_queue #(
   parameter int DEPTH = pfe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  pfe_pkg::pair_type push_pair,
   output logic              push_ready,
   output logic              pop_valid,
   output pfe_pkg::pair_type pop_pair,
   input  logic              pop_ready
);
   import pfe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pair_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_pair   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   assign wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
   assign rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_pair;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with mismatched pointers");

endmodule

@@ src/pfe_back.sv @@
// ----------------------------------------------------------------------------
// pfe_back: digraph cipher and result register
// Locates both letters in the key grid, applies the row, column, rectangle
// or equal-letter (Y) rule and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module pfe_back (
   input  logic              clock,
   input  logic              reset,
   input  pfe_pkg::grid_type grid,
   input  logic              pop_valid,
   input  pfe_pkg::pair_type pop_pair,
   output logic              pop_ready,
   pfe_rsp_if.source         rsp
);
   import pfe_pkg::*;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [LETTER_W-1:0] first_ff, second_ff;
   logic                last_ff, done_ff;
   logic                half_ff, half_in;
   logic                load;
   logic                is_last;
   pos_type             pos_a, pos_b, pos_y;
   pos_type             out_a, out_b;

   always_comb begin
      pos_a = locate(grid, pop_pair.first);
      pos_b = locate(grid, pop_pair.second);
      pos_y = locate(grid, LETTER_Y);
      out_a = pos_a;
      out_b = pos_b;
      if (pop_pair.first == pop_pair.second) begin
         out_a = pos_y;
         out_b = pos_y;
      end else if (pos_a.row == pos_b.row) begin
         out_a.col = wrap_inc(pos_a.col);
         out_b.col = wrap_inc(pos_b.col);
      end else if (pos_a.col == pos_b.col) begin
         out_a.row = wrap_inc(pos_a.row);
         out_b.row = wrap_inc(pos_b.row);
      end else begin
         out_a.col = pos_b.col;
         out_b.col = pos_a.col;
      end
   end

   // A repeated pair goes out twice; hold the job until its second send.
   assign load      = pop_valid && (!rsp_valid_ff || rsp.ready);
   assign is_last   = !(pop_pair.dup && !half_ff);
   assign pop_ready = load && is_last;
   assign half_in   = load ? !is_last : half_ff;
   assign rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         half_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         half_ff      <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         first_ff  <= cell_at(grid, out_a);
         second_ff <= cell_at(grid, out_b);
         last_ff   <= is_last;
         done_ff   <= pop_pair.done && is_last;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.cipher_first  = first_ff;
   assign rsp.cipher_second = second_ff;
   assign rsp.run_last      = last_ff;
   assign rsp.line_done     = done_ff;

   a_done_implies_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> last_ff)
      else $error("line done on a non-final result");

   a_half_needs_job: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> pop_valid && pop_pair.dup)
      else $error("second send pending without a repeated job");

endmodule
